// ----- hw/rtl/refrigeration_defrost_controller_top_assert.svh -----
// Assertion macros for the defrost controller top level.
`ifndef REFRIGERATION_DEFROST_CONTROLLER_TOP_ASSERT_SVH
`define REFRIGERATION_DEFROST_CONTROLLER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rdc_pkg.sv -----
package rdc_pkg;

  localparam logic [31:0] STARTUP_WAIT_MS  = 32'd30000;
  localparam logic [31:0] DEFROST_LIMIT_MS = 32'd1800000;

  // Fixed temperature thresholds, 1/16 degree C
  localparam logic signed [11:0] BACKUP_START_T = -12'sd80;
  localparam logic signed [11:0] BACKUP_STOP_T  = -12'sd240;
  localparam logic signed [12:0] DEMAND_DIFF_T  = 13'sd240;
  localparam logic signed [13:0] LOW_ALARM_T    = 14'sd80;

  // Backup duty cycle: 30 min period, compressor on in the first 15 min.
  // The on half is 900000 ms = 28125 << 5, so the phase is the parity of
  // floor((d >> 5) / 28125), taken by an exact reciprocal multiply.
  localparam int BACKUP_PHASE_SHIFT = 5;
  localparam int BACKUP_RECIP_W     = 28;
  localparam int BACKUP_RECIP_SHIFT = 42;
  localparam logic [BACKUP_RECIP_W-1:0] BACKUP_RECIP = 28'd156374988;

  // Configuration reset values
  localparam logic signed [11:0] SETPOINT_RST         = 12'sd64;
  localparam logic [10:0]        HYSTERESIS_RST       = 11'd32;
  localparam logic [10:0]        ALARM_MARGIN_RST     = 11'd160;
  localparam logic signed [11:0] DEFROST_END_TEMP_RST = 12'sd160;
  localparam logic               DEFROST_KIND_RST     = 1'b0;
  localparam logic [31:0]        MIN_OFF_MS_RST       = 32'd180000;
  localparam logic [31:0]        MIN_ON_MS_RST        = 32'd120000;
  localparam logic [31:0]        DEFROST_INTERVAL_RST = 32'd21600000;

  localparam int CFG_INDEX_W = 3;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_LINK = 2'd1;
  localparam logic [1:0] FAULT_COMP = 2'd2;

  localparam logic DEFROST_HOT_GAS = 1'b0;
  localparam logic DEFROST_HEATER  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SETPOINT,
    CFG_HYSTERESIS,
    CFG_ALARM_MARGIN,
    CFG_DEFROST_END_TEMP,
    CFG_DEFROST_KIND,
    CFG_MIN_OFF_MS,
    CFG_MIN_ON_MS,
    CFG_DEFROST_INTERVAL
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_STARTUP,
    MODE_COOLING,
    MODE_OFFDELAY,
    MODE_DEFROST,
    MODE_ALARM,
    MODE_SAFE,
    MODE_BACKUP
  } mode_t;

  typedef enum logic [2:0] {
    STAT_STARTUP,
    STAT_NORMAL,
    STAT_DEFROST,
    STAT_ALARM,
    STAT_FAULT
  } status_t;

  typedef enum logic [2:0] {
    ALM_NONE,
    ALM_HIGH,
    ALM_LOW,
    ALM_HIGH_SIL,
    ALM_LOW_SIL
  } alarm_t;

  typedef struct packed {
    logic buzzer;
    logic heater;
    logic hot_gas;
    logic fan;
    logic compressor;
  } relays_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [11:0] cabin_reading;
    logic               cabin_ok;
    logic signed [11:0] evap_reading;
    logic               evap_ok;
    logic [1:0]         fault_code;
    logic               defrost_request;
    logic               alarm_ack;
  } tick_t;

  typedef struct packed {
    logic       compressor_on;
    logic       fan_on;
    logic       hot_gas_on;
    logic       heater_on;
    logic       buzzer_on;
    logic [2:0] mode;
    logic [2:0] system_status;
    logic [2:0] alarm_status;
    logic       defrosting;
  } result_t;

endpackage

// ----- hw/rtl/rdc_if.sv -----
interface rdc_tick_if;
  logic           valid;
  logic           ready;
  rdc_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdc_result_if;
  logic             valid;
  logic             ready;
  rdc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rdc_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/refrigeration_defrost_controller_top.sv -----
// An accepted item passes the input register and then the result register on its way to the result.
// Throughput: one item per cycle while result.ready holds; the whole controller step is one pass of compare/select
// logic plus one 27x28 multiply for the backup duty-cycle phase.
// A new item is taken while a finished result waits, until both registers are full.
// Reset (rst, synchronous, active high) empties both registers, puts the controller in
// startup with all relays off and no alarm, and loads the configuration defaults.
`include "refrigeration_defrost_controller_top_assert.svh"

module refrigeration_defrost_controller_top import rdc_pkg::*; (
  input logic          clk,
  input logic          rst,
  rdc_tick_if.sink     tick,
  rdc_result_if.source result,
  rdc_cfg_if.sink      cfg
);

  // Configuration registers
  logic signed [11:0] cfg_setpoint;
  logic [10:0]        cfg_hysteresis;
  logic [10:0]        cfg_alarm_margin;
  logic signed [11:0] cfg_defrost_end_temp;
  logic               cfg_defrost_kind;
  logic [31:0]        cfg_min_off_ms;
  logic [31:0]        cfg_min_on_ms;
  logic [31:0]        cfg_defrost_interval;

  // Pipeline
  logic    s1_valid;
  tick_t   s1;
  logic    res_valid;
  result_t res_data;
  result_t res_next;
  logic    res_load;
  logic    step;

  // Controller state
  mode_t       mode, mode_next;
  logic [31:0] mode_entry_ms, mode_entry_next;
  logic [31:0] last_defrost_ms, last_defrost_next;
  logic [31:0] defrost_start_ms, defrost_start_next;
  logic [31:0] comp_on_ms, comp_on_next;
  logic [31:0] comp_off_ms, comp_off_next;
  logic        comp_on_valid, comp_on_valid_next;
  logic        comp_off_valid, comp_off_valid_next;
  alarm_t      alarm, alarm_next;
  relays_t     relays, relays_next;
  status_t     status, status_next;
  logic        defrost_flag, defrost_flag_next;
  logic        running;

  // Derived terms
  logic [31:0]        since_entry;
  logic [31:0]        since_defrost;
  logic [31:0]        since_on;
  logic [31:0]        since_off;
  logic [31-BACKUP_PHASE_SHIFT:0] since_entry_hi;
  logic [31-BACKUP_PHASE_SHIFT+BACKUP_RECIP_W:0] phase_prod;
  logic               backup_on_phase;
  logic signed [13:0] cabin_x;
  logic signed [13:0] sp_x;
  logic signed [13:0] hyst_x;
  logic signed [13:0] margin_x;
  logic signed [12:0] cabin_evap_diff;
  logic               want_cool;
  logic               alarm_high;
  logic               alarm_low;
  logic               demand_defrost;
  logic               crit_fault;

  // Handshake
  assign res_load   = !res_valid || result.ready;
  assign step       = s1_valid && res_load;
  assign tick.ready = !s1_valid || step;
  assign cfg.ready  = 1'b1;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1 <= tick.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= res_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_setpoint         <= SETPOINT_RST;
      cfg_hysteresis       <= HYSTERESIS_RST;
      cfg_alarm_margin     <= ALARM_MARGIN_RST;
      cfg_defrost_end_temp <= DEFROST_END_TEMP_RST;
      cfg_defrost_kind     <= DEFROST_KIND_RST;
      cfg_min_off_ms       <= MIN_OFF_MS_RST;
      cfg_min_on_ms        <= MIN_ON_MS_RST;
      cfg_defrost_interval <= DEFROST_INTERVAL_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_SETPOINT:         cfg_setpoint         <= cfg.data[11:0];
        CFG_HYSTERESIS:       cfg_hysteresis       <= cfg.data[10:0];
        CFG_ALARM_MARGIN:     cfg_alarm_margin     <= cfg.data[10:0];
        CFG_DEFROST_END_TEMP: cfg_defrost_end_temp <= cfg.data[11:0];
        CFG_DEFROST_KIND:     cfg_defrost_kind     <= cfg.data[0];
        CFG_MIN_OFF_MS:       cfg_min_off_ms       <= cfg.data;
        CFG_MIN_ON_MS:        cfg_min_on_ms        <= cfg.data;
        CFG_DEFROST_INTERVAL: cfg_defrost_interval <= cfg.data;
      endcase
    end
  end

  assign since_entry   = s1.now_ms - mode_entry_ms;
  assign since_defrost = s1.now_ms - last_defrost_ms;
  assign since_on      = s1.now_ms - comp_on_ms;
  assign since_off     = s1.now_ms - comp_off_ms;

  // Even quotient by the on time means the first half of the period
  assign since_entry_hi  = since_entry[31:BACKUP_PHASE_SHIFT];
  assign phase_prod      = since_entry_hi * BACKUP_RECIP;
  assign backup_on_phase = !phase_prod[BACKUP_RECIP_SHIFT];

  assign cabin_x         = 14'(s1.cabin_reading);
  assign sp_x            = 14'(cfg_setpoint);
  assign hyst_x          = {3'b000, cfg_hysteresis};
  assign margin_x        = {3'b000, cfg_alarm_margin};
  assign cabin_evap_diff = 13'(s1.cabin_reading) - 13'(s1.evap_reading);
  assign want_cool       = cabin_x > (sp_x + hyst_x);
  assign alarm_high      = cabin_x > (sp_x + margin_x);
  assign alarm_low       = cabin_x < (sp_x - LOW_ALARM_T);
  assign demand_defrost  = s1.evap_ok && (cabin_evap_diff > DEMAND_DIFF_T);
  assign crit_fault      = (s1.fault_code == FAULT_LINK) || (s1.fault_code == FAULT_COMP);

  // One controller step
  always_comb begin
    mode_next           = mode;
    mode_entry_next     = mode_entry_ms;
    last_defrost_next   = last_defrost_ms;
    defrost_start_next  = defrost_start_ms;
    comp_on_next        = comp_on_ms;
    comp_off_next       = comp_off_ms;
    comp_on_valid_next  = comp_on_valid;
    comp_off_valid_next = comp_off_valid;
    alarm_next          = alarm;
    relays_next         = relays;
    status_next         = status;
    defrost_flag_next   = defrost_flag;
    running             = relays.compressor;

    // Acknowledge comes first
    if (s1.alarm_ack) begin
      if (alarm_next == ALM_HIGH) begin
        alarm_next         = ALM_HIGH_SIL;
        relays_next.buzzer = 1'b0;
      end else if (alarm_next == ALM_LOW) begin
        alarm_next         = ALM_LOW_SIL;
        relays_next.buzzer = 1'b0;
      end
    end

    if (crit_fault) begin
      // Shut everything; status, alarm and defrost flag hold
      if (mode_next != MODE_SAFE) begin
        mode_next       = MODE_SAFE;
        mode_entry_next = s1.now_ms;
      end
      relays_next = '0;
    end else begin
      if (s1.defrost_request && mode_next != MODE_DEFROST) begin
        relays_next.compressor = 1'b0;
        relays_next.fan        = 1'b0;
        comp_off_next          = s1.now_ms;
        comp_off_valid_next    = 1'b1;
        if (cfg_defrost_kind == DEFROST_HEATER) begin
          relays_next.heater = 1'b1;
        end else begin
          relays_next.hot_gas = 1'b1;
        end
        defrost_start_next = s1.now_ms;
        last_defrost_next  = s1.now_ms;
        defrost_flag_next  = 1'b1;
        mode_next          = MODE_DEFROST;
        mode_entry_next    = s1.now_ms;
      end

      running = relays_next.compressor;

      unique case (mode_next)
        MODE_STARTUP: begin
          if (since_entry > STARTUP_WAIT_MS) begin
            mode_next       = s1.cabin_ok ? MODE_COOLING : MODE_BACKUP;
            mode_entry_next = s1.now_ms;
          end
        end
        MODE_COOLING: begin
          if (since_defrost > cfg_defrost_interval || demand_defrost) begin
            // Automatic defrost is always hot gas
            relays_next.compressor = 1'b0;
            relays_next.fan        = 1'b0;
            relays_next.hot_gas    = 1'b1;
            comp_off_next          = s1.now_ms;
            comp_off_valid_next    = 1'b1;
            defrost_start_next     = s1.now_ms;
            last_defrost_next      = s1.now_ms;
            defrost_flag_next      = 1'b1;
            mode_next              = MODE_DEFROST;
            mode_entry_next        = s1.now_ms;
          end else if (!s1.cabin_ok) begin
            mode_next       = MODE_BACKUP;
            mode_entry_next = s1.now_ms;
          end else if (want_cool && !running) begin
            if (!comp_off_valid || since_off > cfg_min_off_ms) begin
              relays_next.compressor = 1'b1;
              relays_next.fan        = 1'b1;
              comp_on_next           = s1.now_ms;
              comp_on_valid_next     = 1'b1;
            end
          end else if (s1.cabin_reading <= cfg_setpoint && running) begin
            if (comp_on_valid && since_on > cfg_min_on_ms) begin
              relays_next.compressor = 1'b0;
              relays_next.fan        = 1'b0;
              comp_off_next          = s1.now_ms;
              comp_off_valid_next    = 1'b1;
              mode_next              = MODE_OFFDELAY;
              mode_entry_next        = s1.now_ms;
            end
          end
        end
        MODE_OFFDELAY: begin
          if (since_entry > cfg_min_off_ms) begin
            mode_next       = MODE_COOLING;
            mode_entry_next = s1.now_ms;
          end
        end
        MODE_DEFROST: begin
          relays_next.fan = 1'b1;
          if ((s1.now_ms - defrost_start_next) > DEFROST_LIMIT_MS ||
              (s1.evap_ok && s1.evap_reading >= cfg_defrost_end_temp)) begin
            // Heaters off, fan left running
            relays_next.hot_gas = 1'b0;
            relays_next.heater  = 1'b0;
            defrost_flag_next   = 1'b0;
            mode_next           = MODE_COOLING;
            mode_entry_next     = s1.now_ms;
          end
        end
        MODE_ALARM: begin
          if (!alarm_high && !alarm_low) begin
            alarm_next      = ALM_NONE;
            mode_next       = MODE_COOLING;
            mode_entry_next = s1.now_ms;
          end
        end
        MODE_SAFE: begin
          relays_next = '0;
          if (s1.fault_code == FAULT_NONE) begin
            mode_next       = MODE_COOLING;
            mode_entry_next = s1.now_ms;
          end
        end
        default: begin
          // Backup: evaporator thermostat, else fixed duty cycle
          if (s1.evap_ok) begin
            if (s1.evap_reading > BACKUP_START_T && !running) begin
              relays_next.compressor = 1'b1;
              relays_next.fan        = 1'b1;
              comp_on_next           = s1.now_ms;
              comp_on_valid_next     = 1'b1;
            end else if (s1.evap_reading < BACKUP_STOP_T && running) begin
              relays_next.compressor = 1'b0;
              relays_next.fan        = 1'b0;
              comp_off_next          = s1.now_ms;
              comp_off_valid_next    = 1'b1;
            end
          end else begin
            if (backup_on_phase && !running) begin
              relays_next.compressor = 1'b1;
              relays_next.fan        = 1'b1;
              comp_on_next           = s1.now_ms;
              comp_on_valid_next     = 1'b1;
            end else if (!backup_on_phase && running) begin
              relays_next.compressor = 1'b0;
              relays_next.fan        = 1'b0;
              comp_off_next          = s1.now_ms;
              comp_off_valid_next    = 1'b1;
            end
          end
          if (s1.cabin_ok) begin
            mode_next       = MODE_COOLING;
            mode_entry_next = s1.now_ms;
          end
        end
      endcase

      // Raise a new alarm from any mode, other relays kept
      if (alarm_high) begin
        if (alarm_next == ALM_NONE) begin
          alarm_next         = ALM_HIGH;
          relays_next.buzzer = 1'b1;
          if (mode_next != MODE_ALARM) begin
            mode_next       = MODE_ALARM;
            mode_entry_next = s1.now_ms;
          end
        end
      end else if (alarm_low) begin
        if (alarm_next == ALM_NONE) begin
          alarm_next         = ALM_LOW;
          relays_next.buzzer = 1'b1;
          if (mode_next != MODE_ALARM) begin
            mode_next       = MODE_ALARM;
            mode_entry_next = s1.now_ms;
          end
        end
      end

      unique case (mode_next)
        MODE_STARTUP:          status_next = STAT_STARTUP;
        MODE_DEFROST:          status_next = STAT_DEFROST;
        MODE_ALARM:            status_next = STAT_ALARM;
        MODE_SAFE, MODE_BACKUP: status_next = STAT_FAULT;
        default:               status_next = STAT_NORMAL;
      endcase
    end

    res_next.compressor_on = relays_next.compressor;
    res_next.fan_on        = relays_next.fan;
    res_next.hot_gas_on    = relays_next.hot_gas;
    res_next.heater_on     = relays_next.heater;
    res_next.buzzer_on     = relays_next.buzzer;
    res_next.mode          = mode_next;
    res_next.system_status = status_next;
    res_next.alarm_status  = alarm_next;
    res_next.defrosting    = defrost_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_STARTUP;
      mode_entry_ms    <= '0;
      last_defrost_ms  <= '0;
      defrost_start_ms <= '0;
      comp_on_ms       <= '0;
      comp_off_ms      <= '0;
      comp_on_valid    <= 1'b0;
      comp_off_valid   <= 1'b0;
      alarm            <= ALM_NONE;
      relays           <= '0;
      status           <= STAT_STARTUP;
      defrost_flag     <= 1'b0;
    end else if (step) begin
      mode             <= mode_next;
      mode_entry_ms    <= mode_entry_next;
      last_defrost_ms  <= last_defrost_next;
      defrost_start_ms <= defrost_start_next;
      comp_on_ms       <= comp_on_next;
      comp_off_ms      <= comp_off_next;
      comp_on_valid    <= comp_on_valid_next;
      comp_off_valid   <= comp_off_valid_next;
      alarm            <= alarm_next;
      relays           <= relays_next;
      status           <= status_next;
      defrost_flag     <= defrost_flag_next;
    end
  end

  `RDC_ASSERT_SAME(a_safe_relays_off, mode == MODE_SAFE, relays == '0, "relay on in safe mode")
  `RDC_ASSERT_SAME(a_defrost_flagged, mode == MODE_DEFROST, defrost_flag, "defrost without flag")
  `RDC_ASSERT_NEXT(a_state_holds, !step, $stable(mode) && $stable(relays) && $stable(alarm),
                   "state moved without a step")
  `RDC_ASSERT_SAME(a_full_stall, s1_valid && res_valid && !result.ready, !tick.ready,
                   "tick taken with both registers full")

endmodule

// ----- tb/sv/rdc_output_checker.sv -----
`timescale 1ns / 1ps

module rdc_output_checker import rdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rdc_tick_if        tick,
  rdc_result_if      result,
  rdc_cfg_if         cfg,
  output int         mismatch_count,
  output int         outputs_due,
  output int         outputs_seen,
  output logic [6:0] modes_reached
);

  localparam int          EVAP_RUN_T     = -80;
  localparam int          EVAP_REST_T    = -240;
  localparam int          FROST_SPLIT_T  = 240;
  localparam int          LOW_BAND_T     = 80;
  localparam logic [31:0] DUTY_PERIOD_MS = 32'd1800000;
  localparam logic [31:0] DUTY_ON_MS     = 32'd900000;

  logic signed [11:0] setpoint_c;
  logic [10:0]        hyst_c;
  logic [10:0]        alarm_margin_c;
  logic signed [11:0] frost_end_c;
  logic               heater_kind_c;
  logic [31:0]        min_off_c;
  logic [31:0]        min_on_c;
  logic [31:0]        frost_interval_c;

  mode_t       mode_q;
  logic [31:0] mode_since;
  logic [31:0] last_frost;
  logic [31:0] frost_start;
  logic [31:0] comp_start_ms;
  logic [31:0] comp_stop_ms;
  logic        comp_start_vld;
  logic        comp_stop_vld;
  alarm_t      alarm_q;
  relays_t     relays_q;
  status_t     status_q;
  logic        frosting_q;

  result_t controller_outputs_due[$];
  result_t want;
  result_t got;

  task automatic switch_mode(input mode_t m, input logic [31:0] now);
    if (m != mode_q) begin
      mode_q = m;
      mode_since = now;
    end
  endtask

  task automatic compressor_run(input logic [31:0] now);
    relays_q.compressor = 1'b1;
    relays_q.fan = 1'b1;
    comp_start_ms = now;
    comp_start_vld = 1'b1;
  endtask

  task automatic compressor_rest(input logic [31:0] now);
    relays_q.compressor = 1'b0;
    relays_q.fan = 1'b0;
    comp_stop_ms = now;
    comp_stop_vld = 1'b1;
  endtask

  task automatic start_defrost(input logic heater, input logic [31:0] now);
    compressor_rest(now);
    if (heater == DEFROST_HEATER) relays_q.heater = 1'b1;
    else relays_q.hot_gas = 1'b1;
    frost_start = now;
    last_frost = now;
    frosting_q = 1'b1;
    switch_mode(MODE_DEFROST, now);
  endtask

  task automatic controller_step(input tick_t t, output result_t r);
    int          cabin;
    int          evap;
    int          sp;
    int          hi_limit;
    int          lo_limit;
    logic        running;
    logic [31:0] now;
    logic [31:0] duty;
    now = t.now_ms;
    cabin = int'($signed(t.cabin_reading));
    evap = int'($signed(t.evap_reading));
    sp = int'(setpoint_c);
    hi_limit = sp + int'(alarm_margin_c);
    lo_limit = sp - LOW_BAND_T;

    // silence before anything else looks at the alarm
    if (t.alarm_ack) begin
      if (alarm_q == ALM_HIGH) begin
        alarm_q = ALM_HIGH_SIL;
        relays_q.buzzer = 1'b0;
      end else if (alarm_q == ALM_LOW) begin
        alarm_q = ALM_LOW_SIL;
        relays_q.buzzer = 1'b0;
      end
    end

    if (t.fault_code == FAULT_LINK || t.fault_code == FAULT_COMP) begin
      // status, alarm and defrost flag hold on a critical fault
      switch_mode(MODE_SAFE, now);
      relays_q = '0;
    end else begin
      if (t.defrost_request && mode_q != MODE_DEFROST) start_defrost(heater_kind_c, now);
      running = relays_q.compressor;
      case (mode_q)
        MODE_STARTUP: begin
          if (now - mode_since > STARTUP_WAIT_MS) begin
            if (t.cabin_ok) switch_mode(MODE_COOLING, now);
            else switch_mode(MODE_BACKUP, now);
          end
        end
        MODE_COOLING: begin
          if (now - last_frost > frost_interval_c ||
              (t.evap_ok && cabin - evap > FROST_SPLIT_T)) begin
            start_defrost(DEFROST_HOT_GAS, now);
          end else if (!t.cabin_ok) begin
            switch_mode(MODE_BACKUP, now);
          end else if (cabin > sp + int'(hyst_c) && !running) begin
            // no stop yet recorded: start allowed
            if (!comp_stop_vld || now - comp_stop_ms > min_off_c) compressor_run(now);
          end else if (cabin <= sp && running) begin
            // no start yet recorded: stop refused
            if (comp_start_vld && now - comp_start_ms > min_on_c) begin
              compressor_rest(now);
              switch_mode(MODE_OFFDELAY, now);
            end
          end
        end
        MODE_OFFDELAY: begin
          if (now - mode_since > min_off_c) switch_mode(MODE_COOLING, now);
        end
        MODE_DEFROST: begin
          relays_q.fan = 1'b1;
          if (now - frost_start > DEFROST_LIMIT_MS ||
              (t.evap_ok && evap >= int'(frost_end_c))) begin
            relays_q.hot_gas = 1'b0;
            relays_q.heater = 1'b0;
            frosting_q = 1'b0;
            switch_mode(MODE_COOLING, now);
          end
        end
        MODE_ALARM: begin
          if (!(cabin > hi_limit) && !(cabin < lo_limit)) begin
            alarm_q = ALM_NONE;
            switch_mode(MODE_COOLING, now);
          end
        end
        MODE_SAFE: begin
          relays_q = '0;
          if (t.fault_code == FAULT_NONE) switch_mode(MODE_COOLING, now);
        end
        default: begin
          if (t.evap_ok) begin
            if (evap > EVAP_RUN_T && !running) compressor_run(now);
            else if (evap < EVAP_REST_T && running) compressor_rest(now);
          end else begin
            // fixed duty cycle counted from entry to backup
            duty = (now - mode_since) % DUTY_PERIOD_MS;
            if (duty < DUTY_ON_MS && !running) compressor_run(now);
            else if (duty >= DUTY_ON_MS && running) compressor_rest(now);
          end
          if (t.cabin_ok) switch_mode(MODE_COOLING, now);
        end
      endcase

      if (cabin > hi_limit) begin
        if (alarm_q == ALM_NONE) begin
          alarm_q = ALM_HIGH;
          relays_q.buzzer = 1'b1;
          switch_mode(MODE_ALARM, now);
        end
      end else if (cabin < lo_limit) begin
        if (alarm_q == ALM_NONE) begin
          alarm_q = ALM_LOW;
          relays_q.buzzer = 1'b1;
          switch_mode(MODE_ALARM, now);
        end
      end

      case (mode_q)
        MODE_STARTUP:            status_q = STAT_STARTUP;
        MODE_DEFROST:            status_q = STAT_DEFROST;
        MODE_ALARM:              status_q = STAT_ALARM;
        MODE_SAFE, MODE_BACKUP:  status_q = STAT_FAULT;
        default:                 status_q = STAT_NORMAL;
      endcase
    end

    r.compressor_on = relays_q.compressor;
    r.fan_on = relays_q.fan;
    r.hot_gas_on = relays_q.hot_gas;
    r.heater_on = relays_q.heater;
    r.buzzer_on = relays_q.buzzer;
    r.mode = mode_q;
    r.system_status = status_q;
    r.alarm_status = alarm_q;
    r.defrosting = frosting_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("output %0d: %s is %0d, predicted %0d", outputs_seen, name, got_v, want_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      setpoint_c = SETPOINT_RST;
      hyst_c = HYSTERESIS_RST;
      alarm_margin_c = ALARM_MARGIN_RST;
      frost_end_c = DEFROST_END_TEMP_RST;
      heater_kind_c = DEFROST_KIND_RST;
      min_off_c = MIN_OFF_MS_RST;
      min_on_c = MIN_ON_MS_RST;
      frost_interval_c = DEFROST_INTERVAL_RST;
      mode_q = MODE_STARTUP;
      mode_since = '0;
      last_frost = '0;
      frost_start = '0;
      comp_start_ms = '0;
      comp_stop_ms = '0;
      comp_start_vld = 1'b0;
      comp_stop_vld = 1'b0;
      alarm_q = ALM_NONE;
      relays_q = '0;
      status_q = STAT_STARTUP;
      frosting_q = 1'b0;
      controller_outputs_due.delete();
      modes_reached = '0;
      outputs_due = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SETPOINT:         setpoint_c = cfg.data[11:0];
          CFG_HYSTERESIS:       hyst_c = cfg.data[10:0];
          CFG_ALARM_MARGIN:     alarm_margin_c = cfg.data[10:0];
          CFG_DEFROST_END_TEMP: frost_end_c = cfg.data[11:0];
          CFG_DEFROST_KIND:     heater_kind_c = cfg.data[0];
          CFG_MIN_OFF_MS:       min_off_c = cfg.data;
          CFG_MIN_ON_MS:        min_on_c = cfg.data;
          CFG_DEFROST_INTERVAL: frost_interval_c = cfg.data;
          default: ;
        endcase
      end

      // compare before taking this edge's item, so a stray output cannot pair with it
      if (result.valid && result.ready) begin
        got = result.data;
        outputs_seen++;
        if (controller_outputs_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("output %0d arrived with no item outstanding", outputs_seen);
        end else begin
          want = controller_outputs_due.pop_front();
          check_field("compressor_on", 32'(got.compressor_on), 32'(want.compressor_on));
          check_field("fan_on", 32'(got.fan_on), 32'(want.fan_on));
          check_field("hot_gas_on", 32'(got.hot_gas_on), 32'(want.hot_gas_on));
          check_field("heater_on", 32'(got.heater_on), 32'(want.heater_on));
          check_field("buzzer_on", 32'(got.buzzer_on), 32'(want.buzzer_on));
          check_field("mode", 32'(got.mode), 32'(want.mode));
          check_field("system_status", 32'(got.system_status), 32'(want.system_status));
          check_field("alarm_status", 32'(got.alarm_status), 32'(want.alarm_status));
          check_field("defrosting", 32'(got.defrosting), 32'(want.defrosting));
        end
      end

      if (tick.valid && tick.ready) begin
        controller_step(tick.data, want);
        controller_outputs_due.push_back(want);
        modes_reached[want.mode] = 1'b1;
      end
      outputs_due = controller_outputs_due.size();
    end
  end

endmodule

// ----- tb/sv/refrigeration_defrost_controller_top_tb.sv -----
`timescale 1ns / 1ps

module refrigeration_defrost_controller_top_tb;
  import rdc_pkg::*;

  localparam logic [1:0] FAULT_OTHER = 2'd3;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_style_t;

  logic clk;
  logic rst;

  rdc_tick_if   tick_ch();
  rdc_result_if result_ch();
  rdc_cfg_if    cfg_ch();

  int         mismatch_count;
  int         outputs_due;
  int         outputs_seen;
  logic [6:0] modes_reached;

  int          ticks_sent = 0;
  int          settings_applied = 0;
  int          hold_off_cycles = 0;
  int          burst_left = 0;
  logic        no_gaps = 1'b0;
  logic [31:0] clock_ms = '0;
  int          cur_sp = int'(SETPOINT_RST);
  int          cur_hyst = int'(HYSTERESIS_RST);
  int          cur_frost_end = int'(DEFROST_END_TEMP_RST);

  refrigeration_defrost_controller_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rdc_output_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick_ch),
    .result         (result_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .outputs_due    (outputs_due),
    .outputs_seen   (outputs_seen),
    .modes_reached  (modes_reached)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // output side: random stall styles in segments, plus a long hold-off on request
  initial begin : receiver
    rx_style_t style;
    int        seg_left;
    style = RX_OPEN;
    seg_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (seg_left == 0) begin
          style = rx_style_t'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 60);
        end
        seg_left--;
        case (style)
          RX_OPEN:   result_ch.ready <= 1'b1;
          RX_HALF:   result_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   result_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic int clamp12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.data <= t;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  task automatic offer(input logic [31:0] now, input int cabin, input logic cabin_ok,
                       input int evap, input logic evap_ok, input logic [1:0] fault,
                       input logic manual, input logic ack);
    tick_t t;
    t.now_ms = now;
    t.cabin_reading = cabin[11:0];
    t.cabin_ok = cabin_ok;
    t.evap_reading = evap[11:0];
    t.evap_ok = evap_ok;
    t.fault_code = fault;
    t.defrost_request = manual;
    t.alarm_ack = ack;
    clock_ms = now;
    send_tick(t);
  endtask

  // mostly plausible readings around the current thresholds, some anywhere in range
  task automatic offer_random(input int upset_pct);
    int          pick;
    int          cabin;
    int          evap;
    logic [31:0] step;
    logic [1:0]  fault;
    pick = $urandom_range(0, 99);
    if (pick < 50) step = $urandom_range(1, 2000);
    else if (pick < 85) step = $urandom_range(1, 200000);
    else if (pick < 97) step = $urandom_range(1, 2000000);
    else step = $urandom;

    pick = $urandom_range(0, 99);
    if (pick < 70)
      cabin = clamp12(cur_sp + int'($urandom_range(0, 400)) - 150);
    else if (pick < 85)
      cabin = clamp12(cur_sp + ($urandom_range(0, 1) ? cur_hyst : 0)
                      + int'($urandom_range(0, 8)) - 4);
    else
      cabin = int'($urandom_range(0, 4095)) - 2048;

    pick = $urandom_range(0, 99);
    if (pick < 45) evap = clamp12(cabin - int'($urandom_range(0, 300)));
    else if (pick < 65) evap = clamp12(cur_frost_end + int'($urandom_range(0, 16)) - 8);
    else if (pick < 85) evap = int'($urandom_range(0, 300)) - 300;
    else evap = int'($urandom_range(0, 4095)) - 2048;

    fault = ($urandom_range(0, 99) < upset_pct) ? 2'($urandom_range(1, 3)) : FAULT_NONE;
    offer(clock_ms + step, cabin, $urandom_range(0, 99) < 92, evap,
          $urandom_range(0, 99) < 85, fault, $urandom_range(0, 99) < upset_pct,
          $urandom_range(0, 9) == 0);
  endtask

  task automatic run_ticks(input int count, input int upset_pct);
    repeat (count) offer_random(upset_pct);
  endtask

  // drop valid, then hold until every output is back and the pipeline is empty
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (outputs_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_settings(input int sp, input int hyst, input int margin,
                                input int frost_end, input logic heater,
                                input logic [31:0] off_ms, input logic [31:0] on_ms,
                                input logic [31:0] interval_ms);
    wait_drained();
    write_reg(CFG_SETPOINT, sp);
    write_reg(CFG_HYSTERESIS, hyst);
    write_reg(CFG_ALARM_MARGIN, margin);
    write_reg(CFG_DEFROST_END_TEMP, frost_end);
    write_reg(CFG_DEFROST_KIND, 32'(heater));
    write_reg(CFG_MIN_OFF_MS, off_ms);
    write_reg(CFG_MIN_ON_MS, on_ms);
    write_reg(CFG_DEFROST_INTERVAL, interval_ms);
    cfg_ch.valid <= 1'b0;
    cur_sp = sp;
    cur_hyst = hyst;
    cur_frost_end = frost_end;
    settings_applied++;
  endtask

  task automatic apply_random_settings();
    apply_settings(int'($urandom_range(0, 4095)) - 2048, $urandom_range(0, 2047),
                   $urandom_range(0, 2047), int'($urandom_range(0, 4095)) - 2048,
                   1'($urandom_range(0, 1)), $urandom_range(0, 300000),
                   $urandom_range(0, 300000), $urandom);
  endtask

  initial begin
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // walk the modes under the default settings
    offer(32'd1000, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd31001, 100, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd32000, 100, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd33000, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd200000, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd390001, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd391000, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b1, 1'b0);
    offer(32'd392000, 64, 1'b1, 200, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd393000, 64, 1'b1, 0, 1'b1, FAULT_LINK, 1'b0, 1'b0);
    offer(32'd394000, 64, 1'b1, 0, 1'b1, FAULT_COMP, 1'b0, 1'b0);
    offer(32'd395000, 64, 1'b1, 0, 1'b1, FAULT_OTHER, 1'b0, 1'b0);
    offer(32'd396000, 64, 1'b0, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd397000, 64, 1'b0, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd398000, 64, 1'b0, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd399000, 64, 1'b0, -300, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd400000, 64, 1'b0, 0, 1'b0, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd1400000, 64, 1'b0, 0, 1'b0, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd1401000, 64, 1'b1, -200, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd1402000, 64, 1'b1, -200, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd3300000, 64, 1'b1, -200, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd3301000, 300, 1'b1, 250, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd3302000, 300, 1'b1, 250, 1'b1, FAULT_NONE, 1'b0, 1'b1);
    offer(32'd3303000, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd3304000, -100, 1'b1, -100, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd3305000, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'hFFFF_FFFF, 2047, 1'b1, -2048, 1'b1, FAULT_NONE, 1'b0, 1'b0);
    offer(32'd5, -2048, 1'b1, 2047, 1'b1, FAULT_NONE, 1'b0, 1'b1);
    offer(32'd6, 64, 1'b1, 0, 1'b1, FAULT_NONE, 1'b0, 1'b0);

    // short on/off times and heater defrost
    apply_settings(0, 16, 200, 100, DEFROST_HEATER, 32'd5000, 32'd4000, 32'd600000);
    run_ticks(80, 2);
    // stall the output long enough that the input backs up
    no_gaps = 1'b1;
    hold_off_cycles = 80;
    run_ticks(30, 2);
    no_gaps = 1'b0;
    wait_drained();
    run_ticks(50, 2);

    apply_settings(-2048, 0, 0, -2048, DEFROST_HOT_GAS, 32'd0, 32'd0, 32'd0);
    run_ticks(160, 2);
    apply_settings(2047, 2047, 2047, 2047, DEFROST_HEATER, '1, '1, '1);
    run_ticks(160, 2);
    apply_random_settings();
    run_ticks(160, 2);
    apply_settings(64, 32, 160, 160, DEFROST_HEATER, 32'd20000, 32'd15000, 32'd3000000);
    run_ticks(160, 1);
    apply_random_settings();
    run_ticks(160, 3);
    apply_settings(-32, 24, 120, 80, DEFROST_HOT_GAS, 32'd60000, 32'd30000, 32'd1200000);
    run_ticks(160, 8);

    wait_drained();
    $display("%0d items sent across defaults and %0d register settings, %0d outputs checked",
             ticks_sent, settings_applied, outputs_seen);
    $display("modes reached, startup in bit 0: %b", modes_reached);
    if (mismatch_count == 0 && outputs_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_if.sv
hw/rtl/refrigeration_defrost_controller_top.sv
tb/sv/rdc_output_checker.sv
tb/sv/refrigeration_defrost_controller_top_tb.sv
